### rtl/core/rilbp_pkg.sv
// Package: shared types, constants and a helper function for the 3x3 rotation-invariant LBP block.
package rilbp_pkg;

	localparam int DEF_MAX_WIDTH     = 1024;
	localparam int DEF_PIXEL_BITS    = 8;
	localparam int PIXEL_FIELD_BITS  = 8;
	localparam int CODE_BITS         = 8;
	localparam int NBR_COUNT         = 8;
	localparam int IMAGE_WIDTH_BITS  = 11;
	localparam int IMAGE_WIDTH_RESET = 1024;
	localparam int MIN_WIDTH         = 3;
	localparam int APB_ADDR_BITS     = 3;
	localparam int APB_DATA_BITS     = 32;
	localparam int REG_INDEX_BITS    = 1;

	localparam logic [REG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 1'b0;

	typedef struct packed {
		logic [PIXEL_FIELD_BITS-1:0] pixel;
		logic                        frame_start;
	} pix_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] lbp_code;
		logic                 row_last;
	} code_t;

	// one stage of the rotation chain
	typedef struct packed {
		logic                 valid;
		logic [CODE_BITS-1:0] rot;
		logic [CODE_BITS-1:0] best;
		logic                 row_last;
	} rot_t;

	function automatic logic [CODE_BITS-1:0] rotl(input logic [CODE_BITS-1:0] v);
		return {v[CODE_BITS-2:0], v[CODE_BITS-1]};
	endfunction

endpackage

### rtl/core/rotation_invariant_lbp_3x3.sv
// Top level: 3x3 rotation-invariant LBP over a raster pixel stream.
//
// channel | signals                      | dir | payload
// pix     | pix_valid / pix_ready        | in  | pix_t  {pixel, frame_start}
// code    | code_valid / code_ready      | out | code_t {lbp_code, row_last}
// cfg     | psel penable pwrite paddr .. | in  | image_width at 0x0
//
// One pixel per clock while the skid register is empty; from pixel to code the path runs through line buffer read,
// compare, seven rotate-and-min cells and the output register.
// Reset clears position, window and pipeline valids; line buffer contents stay undefined.
// A stalled code goes to a skid register; pix_ready drops only while that register is full.
module rotation_invariant_lbp_3x3
	import rilbp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pix_valid,
	output logic                     pix_ready,
	input  pix_t                     pix,
	output logic                     code_valid,
	input  logic                     code_ready,
	output code_t                    code,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int CB = $clog2(MAX_WIDTH);
	localparam int WB = ($clog2(MAX_WIDTH + 1) > IMAGE_WIDTH_BITS) ?
		$clog2(MAX_WIDTH + 1) : IMAGE_WIDTH_BITS;
	localparam int ROT_CELLS = NBR_COUNT - 1;

	// configuration
	logic [IMAGE_WIDTH_BITS-1:0] image_width_q;
	logic                        reg_sel;
	logic                        cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_BITS-1:2] == REG_IMAGE_WIDTH);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = reg_sel ? APB_DATA_BITS'(image_width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_BITS'(IMAGE_WIDTH_RESET);
		end else if (cfg_wr && reg_sel) begin
			image_width_q <= pwdata[IMAGE_WIDTH_BITS-1:0];
		end
	end

	logic [WB-1:0] width_ext;
	logic [WB-1:0] width_used;

	assign width_ext  = WB'(image_width_q);
	assign width_used = (width_ext < WB'(MIN_WIDTH)) ? WB'(MIN_WIDTH) :
		(width_ext > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : width_ext;

	// stall control
	logic  en;
	logic  accept;
	logic  skid_valid_q;
	code_t skid_q;
	logic  out_valid_q;
	code_t out_q;

	assign en        = !skid_valid_q;
	assign pix_ready = en;
	assign accept    = pix_valid && en;

	// position tracking, stage 0
	logic [CB-1:0] col_q;
	logic [1:0]    row_q;
	logic [CB-1:0] col_cur;
	logic [1:0]    row_cur;
	logic          last_cur;
	logic          emit_cur;
	logic [PIXEL_BITS-1:0] px_cur;

	assign col_cur  = pix.frame_start ? '0 : col_q;
	assign row_cur  = pix.frame_start ? '0 : row_q;
	assign last_cur = ((WB'(col_cur) + WB'(1)) >= width_used);
	assign emit_cur = (row_cur == 2'd2) && (col_cur >= CB'(2));
	assign px_cur   = PIXEL_BITS'(pix.pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_cur) begin
				col_q <= '0;
				row_q <= (row_cur < 2'd2) ? row_cur + 2'd1 : row_cur;
			end else begin
				col_q <= col_cur + CB'(1);
				row_q <= row_cur;
			end
		end
	end

	// stage 1
	logic                  valid_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [CB-1:0]         col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1 <= emit_cur;
			last_s1 <= last_cur;
			px_s1   <= px_cur;
			col_s1  <= col_cur;
		end
	end

	logic                       step_s1;
	logic [1:0][PIXEL_BITS-1:0] lb_rd;
	logic [1:0][PIXEL_BITS-1:0] lb_wr;

	assign step_s1 = en && valid_s1;
	assign lb_wr   = {px_s1, lb_rd[1]};

	rilbp_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.PIXEL_BITS(PIXEL_BITS)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (en),
		.rd_addr(col_cur),
		.wr_en  (step_s1),
		.wr_addr(col_s1),
		.wr_data(lb_wr),
		.rd_data(lb_rd)
	);

	// window: column index 0 = top, 1 = middle, 2 = bottom
	logic [2:0][PIXEL_BITS-1:0] win0;
	logic [2:0][PIXEL_BITS-1:0] win1;
	logic [2:0][PIXEL_BITS-1:0] new_col;

	assign new_col = {px_s1, lb_rd[1], lb_rd[0]};

	rilbp_col_cell #(.PIXEL_BITS(PIXEL_BITS)) u_col0 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_s1),
		.col_in (new_col),
		.col_out(win0)
	);

	rilbp_col_cell #(.PIXEL_BITS(PIXEL_BITS)) u_col1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (step_s1),
		.col_in (win0),
		.col_out(win1)
	);

	logic [PIXEL_BITS-1:0] ctr;
	logic [CODE_BITS-1:0]  cmp_code;

	assign ctr = win0[1];
	assign cmp_code = {
		win1[0]  >= ctr,
		win0[0]  >= ctr,
		lb_rd[0] >= ctr,
		lb_rd[1] >= ctr,
		px_s1    >= ctr,
		win0[2]  >= ctr,
		win1[2]  >= ctr,
		win1[1]  >= ctr
	};

	// stage 2 and rotation chain
	rot_t chain [ROT_CELLS+1];
	logic valid_s2;
	logic [CODE_BITS-1:0] code_s2;
	logic last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s2 <= cmp_code;
			last_s2 <= last_s1;
		end
	end

	assign chain[0] = '{valid: valid_s2, rot: code_s2, best: code_s2, row_last: last_s2};

	for (genvar k = 0; k < ROT_CELLS; k++) begin : g_rot
		rilbp_rot_cell u_rot (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.d     (chain[k]),
			.q     (chain[k+1])
		);
	end

	// output register with skid
	logic  inc_valid;
	code_t inc;

	assign inc_valid = en && chain[ROT_CELLS].valid;
	assign inc       = '{lbp_code: chain[ROT_CELLS].best, row_last: chain[ROT_CELLS].row_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || code_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= inc_valid;
			end
		end else if (inc_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || code_ready) begin
			out_q <= skid_valid_q ? skid_q : inc;
		end else if (inc_valid) begin
			skid_q <= inc;
		end
	end

	assign code_valid = out_valid_q;
	assign code       = out_q;

`ifndef SYNTH
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a transaction while output register is empty");

	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd3)
		else $error("row position past saturation");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_cur) |=> (col_q == '0))
		else $error("column did not wrap after last pixel of row");

	a_no_emit_border: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s1 && emit_s1) |=> valid_s2)
		else $error("interior pixel lost before rotation chain");
`endif

endmodule

### rtl/core/rilbp_col_cell.sv
// Window cell: holds one column (top, middle, bottom) of the 3x3 window.
module rilbp_col_cell
	import rilbp_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [2:0][PIXEL_BITS-1:0] col_in,
	output logic [2:0][PIXEL_BITS-1:0] col_out
);

	logic [2:0][PIXEL_BITS-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

### rtl/core/rilbp_rot_cell.sv
// Rotation cell: rotates the code by one bit and keeps the running minimum.
module rilbp_rot_cell
	import rilbp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  rot_t d,
	output rot_t q
);

	logic [CODE_BITS-1:0] nxt_rot;
	logic                 valid_q;
	logic [CODE_BITS-1:0] rot_q;
	logic [CODE_BITS-1:0] best_q;
	logic                 last_q;

	assign nxt_rot = rotl(d.rot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q  <= nxt_rot;
			best_q <= (nxt_rot < d.best) ? nxt_rot : d.best;
			last_q <= d.row_last;
		end
	end

	assign q = '{valid: valid_q, rot: rot_q, best: best_q, row_last: last_q};

endmodule

### rtl/core/rilbp_line_buf.sv
// Line buffer: the two rows above the current one, one column per entry, with write bypass.
module rilbp_line_buf
	import rilbp_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	localparam int AW        = $clog2(MAX_WIDTH)
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [1:0][PIXEL_BITS-1:0] wr_data,
	output logic [1:0][PIXEL_BITS-1:0] rd_data
);

	logic [1:0][PIXEL_BITS-1:0] mem_q [MAX_WIDTH];
	logic [1:0][PIXEL_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule
